>>> rtl/smpc_pkg.sv
// shared types and constants for the stun message parse and check block
`default_nettype none
package smpc_pkg;

	localparam int unsigned MaxDatagramBytes = 2048;

	localparam logic [31:0] FpXor        = 32'h5354554e;
	localparam logic [31:0] MagicCookie  = 32'h2112A442;
	localparam logic [31:0] CrcPoly      = 32'hEDB88320;
	localparam logic [15:0] AttrUsername = 16'h0006;
	localparam logic [15:0] AttrIntegrity = 16'h0008;
	localparam logic [15:0] AttrPriority = 16'h0024;
	localparam logic [15:0] AttrFingerprint = 16'h8028;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_SHORT     = 3'd1,
		ST_NOT_STUN  = 3'd2,
		ST_LEN_BAD   = 3'd3,
		ST_ATTR_BAD  = 3'd4
	} status_t;

	// attribute walker phase, one-hot
	typedef enum logic [5:0] {
		PH_TYPE_HI = 6'b000001,
		PH_TYPE_LO = 6'b000010,
		PH_LEN_HI  = 6'b000100,
		PH_LEN_LO  = 6'b001000,
		PH_BODY    = 6'b010000,
		PH_BAD     = 6'b100000
	} phase_t;

	// end-of-datagram summary handed from the front to the back
	typedef struct packed {
		logic [16:0] byte_count;
		logic        overflow;
		logic [31:0] crc;
		logic [63:0] tail;
		logic [15:0] hdr_type;
		logic [15:0] hdr_len;
		logic [31:0] cookie;
		logic [31:0] txn_high;
		logic [63:0] txn_low;
		logic        walk_idle;
		logic [2:0]  found;
		logic [31:0] priority_val;
		logic [10:0] integrity_pos;
		logic [10:0] username_len;
	} summary_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
		logic [31:0] c;
		c = c_in ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
		end
		return c;
	endfunction

endpackage
`default_nettype wire

>>> rtl/smpc_front.sv
// front part: byte capture, crc, header and attribute walk
`default_nettype none
module smpc_front #(
	parameter int unsigned MAX_BYTES = smpc_pkg::MaxDatagramBytes
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_fire,
	input  wire logic [7:0]         data_byte,
	input  wire logic               last,
	output smpc_pkg::summary_t      summary,
	output logic                    summary_push
);
	localparam int CW = $clog2(MAX_BYTES + 1);

	logic [CW-1:0]      count_q;
	logic               overflow_q;
	logic [31:0]        crc_q;
	logic [63:0]        tail_q;
	logic [15:0]        type_q, len_q;
	logic [31:0]        cookie_q, txn_high_q;
	logic [63:0]        txn_low_q;
	smpc_pkg::phase_t   phase_q;
	logic [15:0]        atype_q, arem_q;
	logic [2:0]         found_q;
	logic [31:0]        prio_q;
	logic [10:0]        ipos_q, ulen_q;

	// next-state values, summary is taken from these
	logic [CW-1:0]      count_d;
	logic               overflow_d;
	logic [31:0]        crc_d;
	logic [63:0]        tail_d;
	logic [15:0]        type_d, len_d;
	logic [31:0]        cookie_d, txn_high_d;
	logic [63:0]        txn_low_d;
	smpc_pkg::phase_t   phase_d;
	logic [15:0]        atype_d, arem_d;
	logic [2:0]         found_d;
	logic [31:0]        prio_d;
	logic [10:0]        ipos_d, ulen_d;
	logic [16:0]        alen, apad;
	logic [31:0]        pos;

	always_comb begin
		count_d = count_q; overflow_d = overflow_q; crc_d = crc_q; tail_d = tail_q;
		type_d = type_q; len_d = len_q; cookie_d = cookie_q; txn_high_d = txn_high_q;
		txn_low_d = txn_low_q; phase_d = phase_q; atype_d = atype_q; arem_d = arem_q;
		found_d = found_q; prio_d = prio_q; ipos_d = ipos_q; ulen_d = ulen_q;
		pos = 32'(count_q);
		alen = {1'b0, arem_q[7:0], data_byte};
		apad = (alen + 17'd3) & ~17'd3;
		if (pos >= MAX_BYTES) begin
			overflow_d = 1'b1;
		end else begin
			if (pos >= 32'd8) crc_d = smpc_pkg::crc_byte(crc_q, tail_q[63:56]);
			tail_d = {tail_q[55:0], data_byte};
			if (pos < 32'd2) type_d = {type_q[7:0], data_byte};
			else if (pos < 32'd4) len_d = {len_q[7:0], data_byte};
			else if (pos < 32'd8) cookie_d = {cookie_q[23:0], data_byte};
			else if (pos < 32'd12) txn_high_d = {txn_high_q[23:0], data_byte};
			else if (pos < 32'd20) txn_low_d = {txn_low_q[55:0], data_byte};
			else begin
				unique case (phase_q)
					smpc_pkg::PH_TYPE_HI: begin
						atype_d = {data_byte, 8'd0};
						phase_d = smpc_pkg::PH_TYPE_LO;
					end
					smpc_pkg::PH_TYPE_LO: begin
						atype_d = {atype_q[15:8], data_byte};
						phase_d = smpc_pkg::PH_LEN_HI;
					end
					smpc_pkg::PH_LEN_HI: begin
						arem_d = {8'd0, data_byte};
						phase_d = smpc_pkg::PH_LEN_LO;
					end
					smpc_pkg::PH_LEN_LO: begin
						if (atype_q == smpc_pkg::AttrPriority && alen != 17'd4) begin
							phase_d = smpc_pkg::PH_BAD;
						end else begin
							if (atype_q == smpc_pkg::AttrUsername && !found_q[0]) begin
								found_d[0] = 1'b1;
								ulen_d = alen[10:0];
							end
							if (atype_q == smpc_pkg::AttrIntegrity && !found_q[1]) begin
								found_d[1] = 1'b1;
								ipos_d = pos[10:0] - 11'd3;
							end
							if (apad == 17'd0) begin
								phase_d = smpc_pkg::PH_TYPE_HI;
							end else begin
								arem_d = apad[15:0] - 16'd1;
								phase_d = smpc_pkg::PH_BODY;
							end
						end
					end
					smpc_pkg::PH_BODY: begin
						if (atype_q == smpc_pkg::AttrPriority && !found_q[2]) begin
							prio_d = {prio_q[23:0], data_byte};
							if (arem_q == 16'd0) found_d[2] = 1'b1;
						end
						if (arem_q == 16'd0) phase_d = smpc_pkg::PH_TYPE_HI;
						else arem_d = arem_q - 16'd1;
					end
					default: phase_d = smpc_pkg::PH_BAD;
				endcase
			end
			count_d = count_q + CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0; overflow_q <= 1'b0; crc_q <= '1; tail_q <= '0;
			type_q <= '0; len_q <= '0; cookie_q <= '0; txn_high_q <= '0; txn_low_q <= '0;
			phase_q <= smpc_pkg::PH_TYPE_HI; atype_q <= '0; arem_q <= '0;
			found_q <= '0; prio_q <= '0; ipos_q <= '0; ulen_q <= '0;
		end else if (in_fire) begin
			if (last) begin
				count_q <= '0; overflow_q <= 1'b0; crc_q <= '1; tail_q <= '0;
				type_q <= '0; len_q <= '0; cookie_q <= '0; txn_high_q <= '0;
				txn_low_q <= '0; phase_q <= smpc_pkg::PH_TYPE_HI; atype_q <= '0;
				arem_q <= '0; found_q <= '0; prio_q <= '0; ipos_q <= '0; ulen_q <= '0;
			end else begin
				count_q <= count_d; overflow_q <= overflow_d; crc_q <= crc_d;
				tail_q <= tail_d; type_q <= type_d; len_q <= len_d; cookie_q <= cookie_d;
				txn_high_q <= txn_high_d; txn_low_q <= txn_low_d; phase_q <= phase_d;
				atype_q <= atype_d; arem_q <= arem_d; found_q <= found_d;
				prio_q <= prio_d; ipos_q <= ipos_d; ulen_q <= ulen_d;
			end
		end
	end

	always_comb begin
		summary.byte_count    = 17'(count_d);
		summary.overflow      = overflow_d;
		summary.crc           = crc_d;
		summary.tail          = tail_d;
		summary.hdr_type      = type_d;
		summary.hdr_len       = len_d;
		summary.cookie        = cookie_d;
		summary.txn_high      = txn_high_d;
		summary.txn_low       = txn_low_d;
		summary.walk_idle     = (phase_d == smpc_pkg::PH_TYPE_HI);
		summary.found         = found_d;
		summary.priority_val  = prio_d;
		summary.integrity_pos = ipos_d;
		summary.username_len  = ulen_d;
	end
	assign summary_push = in_fire && last;

	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(phase_q))
		else $error("phase not one-hot");
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		summary_push |=> count_q == '0 && crc_q == '1)
		else $error("state not cleared after datagram end");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= MAX_BYTES)
		else $error("byte count beyond limit");
endmodule
`default_nettype wire

>>> rtl/smpc_queue.sv
// short fifo of datagram summaries between front and back
`default_nettype none
module smpc_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire smpc_pkg::summary_t push_data,
	output logic                    full,
	input  wire logic               pop,
	output smpc_pkg::summary_t      pop_data,
	output logic                    not_empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	smpc_pkg::summary_t mem_q [DEPTH];
	logic [AW-1:0]      wr_q, rd_q;
	logic [AW:0]        fill_q;

	assign full      = (fill_q == (AW+1)'(DEPTH));
	assign not_empty = (fill_q != '0);
	assign pop_data  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0; rd_q <= '0; fill_q <= '0;
		end else begin
			if (push && !full) wr_q <= (wr_q == AW'(DEPTH-1)) ? '0 : wr_q + AW'(1);
			if (pop && not_empty) rd_q <= (rd_q == AW'(DEPTH-1)) ? '0 : rd_q + AW'(1);
			fill_q <= fill_q + (AW+1)'(push && !full) - (AW+1)'(pop && not_empty);
		end
	end

	a_fill: assert property (@(posedge clk) disable iff (!arst_n) fill_q <= (AW+1)'(DEPTH))
		else $error("queue fill beyond depth");
	a_nopush_full: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("push into full queue");
	a_nopop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q == '0) |=> !$fell(fill_q == '0) || $past(push))
		else $error("queue fill moved without push");
endmodule
`default_nettype wire

>>> rtl/smpc_back.sv
// back part: status, fingerprint verdict and result register
`default_nettype none
module smpc_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire smpc_pkg::summary_t sm,
	input  wire logic               sm_valid,
	output logic                    sm_pop,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [2:0]              status,
	output logic [15:0]             message_type,
	output logic                    cookie_ok,
	output logic [31:0]             txn_id_high,
	output logic [63:0]             txn_id_low,
	output logic                    fingerprint_ok,
	output logic                    has_integrity,
	output logic [10:0]             integrity_offset,
	output logic                    has_priority,
	output logic [31:0]             priority_value,
	output logic                    has_username,
	output logic [10:0]             username_length
);
	smpc_pkg::status_t st;
	logic        ck, fp, ok, load;
	logic [16:0] n;
	logic [31:0] val;

	always_comb begin
		n = sm.byte_count;
		if (n < 17'd2) st = smpc_pkg::ST_SHORT;
		else if (sm.hdr_type[11]) st = smpc_pkg::ST_NOT_STUN;
		else if (n < 17'd20) st = smpc_pkg::ST_SHORT;
		else if (sm.overflow || (n - 17'd20) != {1'b0, sm.hdr_len}) st = smpc_pkg::ST_LEN_BAD;
		else if (!sm.walk_idle) st = smpc_pkg::ST_ATTR_BAD;
		else st = smpc_pkg::ST_OK;
		ck  = (n >= 17'd8) && sm.cookie == smpc_pkg::MagicCookie;
		val = sm.tail[31:0];
		fp  = !sm.overflow && n[1:0] == 2'd0 && n >= 17'd28 && ck &&
			sm.tail[63:48] == smpc_pkg::AttrFingerprint && sm.tail[47:40] == 8'd0 &&
			sm.tail[39:32] == 8'd4 && (val ^ smpc_pkg::FpXor) == ~sm.crc;
		ok  = (st == smpc_pkg::ST_OK);
	end

	assign load   = sm_valid && (!out_valid || out_ready);
	assign sm_pop = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (load) out_valid <= 1'b1;
		else if (out_ready) out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			status           <= st;
			message_type     <= (n >= 17'd2) ? sm.hdr_type : 16'd0;
			cookie_ok        <= ck;
			txn_id_high      <= (n >= 17'd12) ? sm.txn_high : 32'd0;
			txn_id_low       <= (n >= 17'd20) ? sm.txn_low : 64'd0;
			fingerprint_ok   <= fp;
			has_integrity    <= ok && sm.found[1];
			integrity_offset <= (ok && sm.found[1]) ? sm.integrity_pos : 11'd0;
			has_priority     <= ok && sm.found[2];
			priority_value   <= (ok && sm.found[2]) ? sm.priority_val : 32'd0;
			has_username     <= ok && sm.found[0];
			username_length  <= (ok && sm.found[0]) ? sm.username_len : 11'd0;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status))
		else $error("result dropped while stalled");
	a_ok_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != 3'(smpc_pkg::ST_OK) |-> !has_integrity && !has_priority
		&& !has_username)
		else $error("findings on failed parse");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= 3'(smpc_pkg::ST_ATTR_BAD))
		else $error("bad status code");
endmodule
`default_nettype wire

>>> rtl/stun_message_parse_check.sv
// top level of the stun message parser and fingerprint checker
// One datagram byte is taken per cycle in wire order, back to back, with
// end_of_datagram on its final byte; the byte-wide crc and attribute walk
// each advance on every accepted byte. A single result per datagram is
// loaded from the summary queue and waits in an output
// register; a two-entry summary queue lets further datagrams stream in while
// results stall. Input stalls only when that queue is full. Bytes beyond
// MAX_DATAGRAM_BYTES are dropped.
`default_nettype none
module stun_message_parse_check #(
	parameter int unsigned MAX_DATAGRAM_BYTES = smpc_pkg::MaxDatagramBytes
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        end_of_datagram,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       status,
	output logic [15:0]      message_type,
	output logic             cookie_ok,
	output logic [31:0]      txn_id_high,
	output logic [63:0]      txn_id_low,
	output logic             fingerprint_ok,
	output logic             has_integrity,
	output logic [10:0]      integrity_offset,
	output logic             has_priority,
	output logic [31:0]      priority_value,
	output logic             has_username,
	output logic [10:0]      username_length
);
	smpc_pkg::summary_t sum_in, sum_out;
	logic push, full, pop, nempty, fire;

	assign in_ready = !full;
	assign fire     = in_valid && in_ready;

	smpc_front #(.MAX_BYTES(MAX_DATAGRAM_BYTES)) u_front (
		.clk, .arst_n, .in_fire(fire), .data_byte, .last(end_of_datagram),
		.summary(sum_in), .summary_push(push)
	);

	smpc_queue #(.DEPTH(2)) u_queue (
		.clk, .arst_n, .push, .push_data(sum_in), .full,
		.pop, .pop_data(sum_out), .not_empty(nempty)
	);

	smpc_back u_back (
		.clk, .arst_n, .sm(sum_out), .sm_valid(nempty), .sm_pop(pop),
		.out_valid, .out_ready, .status, .message_type, .cookie_ok, .txn_id_high,
		.txn_id_low, .fingerprint_ok, .has_integrity, .integrity_offset,
		.has_priority, .priority_value, .has_username, .username_length
	);
endmodule
`default_nettype wire

>>> tb/tb_top.sv
// testbench for the stun message parse and fingerprint check block
`timescale 1ns / 1ps
module tb_top;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] mtype;
		logic        cookie;
		logic [31:0] txn_hi;
		logic [63:0] txn_lo;
		logic        fp;
		logic        has_mi;
		logic [10:0] mi_off;
		logic        has_prio;
		logic [31:0] prio;
		logic        has_user;
		logic [10:0] user_len;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] data_byte = 8'd0;
	logic end_of_datagram = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [2:0] status;
	logic [15:0] message_type;
	logic cookie_ok;
	logic [31:0] txn_id_high;
	logic [63:0] txn_id_low;
	logic fingerprint_ok;
	logic has_integrity;
	logic [10:0] integrity_offset;
	logic has_priority;
	logic [31:0] priority_value;
	logic has_username;
	logic [10:0] username_length;

	stun_message_parse_check dut (.*);

	always #5 clk = ~clk;

	req_t     pending_bytes[$];
	verdict_t expected_verdicts[$];
	int       failures = 0;
	int       queued = 0;        // bytes handed to the driver so far
	bit       in_taken = 0;      // request accepted at the last rising edge
	bit       calm = 0;          // no random idling
	int       rx_hold = 0;       // receiver hold-off, in cycles
	bit       sender_pause = 0;

	// parser copy used to predict verdicts
	int unsigned p_count;
	bit          p_over;
	logic [31:0] p_crc;
	logic [7:0]  p_tail[8];
	logic [15:0] p_type, p_len, p_atype, p_arem;
	logic [31:0] p_cookie, p_thi, p_prio;
	logic [63:0] p_tlo;
	smpc_pkg::phase_t p_phase;
	logic [2:0]  p_found;  // user, integrity, priority
	logic [10:0] p_mipos, p_ulen;

	function automatic logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
		c = c ^ {24'd0, b};
		for (int i = 0; i < 8; i++)
			c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
		return c;
	endfunction

	task automatic parser_clear();
		p_count = 0; p_over = 0; p_crc = '1;
		foreach (p_tail[i]) p_tail[i] = 8'd0;
		p_type = 0; p_len = 0; p_cookie = 0; p_thi = 0; p_tlo = 0;
		p_phase = smpc_pkg::PH_TYPE_HI; p_atype = 0; p_arem = 0; p_found = 0;
		p_prio = 0; p_mipos = 0; p_ulen = 0;
	endtask

	task automatic attr_walk(int unsigned pos, logic [7:0] b);
		logic [16:0] alen, padded;
		case (p_phase)
		smpc_pkg::PH_TYPE_HI: begin p_atype = {b, 8'd0}; p_phase = smpc_pkg::PH_TYPE_LO; end
		smpc_pkg::PH_TYPE_LO: begin p_atype[7:0] = b; p_phase = smpc_pkg::PH_LEN_HI; end
		smpc_pkg::PH_LEN_HI: begin p_arem = {8'd0, b}; p_phase = smpc_pkg::PH_LEN_LO; end
		smpc_pkg::PH_LEN_LO: begin
			alen = {1'b0, p_arem[7:0], b};
			padded = (alen + 17'd3) & ~17'd3;
			if (p_atype == smpc_pkg::AttrPriority && alen != 17'd4) begin
				p_phase = smpc_pkg::PH_BAD;
			end else begin
				if (p_atype == smpc_pkg::AttrUsername && !p_found[0]) begin
					p_found[0] = 1; p_ulen = alen[10:0];
				end
				if (p_atype == smpc_pkg::AttrIntegrity && !p_found[1]) begin
					p_found[1] = 1; p_mipos = 11'(pos - 3);
				end
				if (padded == 0) p_phase = smpc_pkg::PH_TYPE_HI;
				else begin p_arem = 16'(padded - 1); p_phase = smpc_pkg::PH_BODY; end
			end
		end
		smpc_pkg::PH_BODY: begin
			if (p_atype == smpc_pkg::AttrPriority && !p_found[2]) begin
				p_prio = {p_prio[23:0], b};
				if (p_arem == 0) p_found[2] = 1;
			end
			if (p_arem == 0) p_phase = smpc_pkg::PH_TYPE_HI;
			else p_arem--;
		end
		default: p_phase = smpc_pkg::PH_BAD;
		endcase
	endtask

	task automatic predict_byte(req_t r);
		verdict_t v;
		int unsigned n;
		bit ok;
		if (p_count >= smpc_pkg::MaxDatagramBytes) begin
			p_over = 1;
		end else begin
			if (p_count >= 8) p_crc = crc_step(p_crc, p_tail[7]);
			for (int i = 7; i > 0; i--) p_tail[i] = p_tail[i-1];
			p_tail[0] = r.data;
			if (p_count < 2) p_type = {p_type[7:0], r.data};
			else if (p_count < 4) p_len = {p_len[7:0], r.data};
			else if (p_count < 8) p_cookie = {p_cookie[23:0], r.data};
			else if (p_count < 12) p_thi = {p_thi[23:0], r.data};
			else if (p_count < 20) p_tlo = {p_tlo[55:0], r.data};
			else attr_walk(p_count, r.data);
			p_count++;
		end
		if (!r.last) return;
		n = p_count;
		if (n < 2) v.status = smpc_pkg::ST_SHORT;
		else if (p_type[11]) v.status = smpc_pkg::ST_NOT_STUN;
		else if (n < 20) v.status = smpc_pkg::ST_SHORT;
		else if (p_over || n - 20 != p_len) v.status = smpc_pkg::ST_LEN_BAD;
		else if (p_phase != smpc_pkg::PH_TYPE_HI) v.status = smpc_pkg::ST_ATTR_BAD;
		else v.status = smpc_pkg::ST_OK;
		ok = v.status == smpc_pkg::ST_OK;
		v.mtype = n >= 2 ? p_type : 16'd0;
		v.cookie = n >= 8 && p_cookie == smpc_pkg::MagicCookie;
		v.txn_hi = n >= 12 ? p_thi : 32'd0;
		v.txn_lo = n >= 20 ? p_tlo : 64'd0;
		v.fp = !p_over && n[1:0] == 0 && n >= 28 && v.cookie &&
			{p_tail[7], p_tail[6]} == smpc_pkg::AttrFingerprint && p_tail[5] == 0 &&
			p_tail[4] == 4 &&
			(({p_tail[3], p_tail[2], p_tail[1], p_tail[0]} ^ smpc_pkg::FpXor) == ~p_crc);
		v.has_mi = ok && p_found[1];
		v.mi_off = v.has_mi ? p_mipos : 11'd0;
		v.has_prio = ok && p_found[2];
		v.prio = v.has_prio ? p_prio : 32'd0;
		v.has_user = ok && p_found[0];
		v.user_len = v.has_user ? p_ulen : 11'd0;
		expected_verdicts = {expected_verdicts, v};
		parser_clear();
	endtask

	// datagram building
	logic [7:0] dg[$];

	task automatic put8(logic [7:0] b);
		dg = {dg, b};
	endtask

	task automatic put32(logic [31:0] w);
		for (int i = 3; i >= 0; i--) put8(w[i*8 +: 8]);
	endtask

	task automatic put_attr(logic [15:0] t, int len, int pad_len);
		put8(t[15:8]); put8(t[7:0]);
		put8(len[15:8]); put8(len[7:0]);
		for (int i = 0; i < pad_len; i++) put8(8'($urandom));
	endtask

	// well-formed message with random attributes, optional fingerprint
	task automatic build_message(bit with_fp, bit corrupt_fp);
		logic [31:0] c;
		int na, len, body;
		logic [15:0] t;
		dg.delete();
		put32({2'b00, 14'($urandom) & ~14'h0800, 16'd0});
		put32(smpc_pkg::MagicCookie);
		put32($urandom); put32($urandom); put32($urandom);
		na = $urandom_range(0, 5);
		for (int k = 0; k < na; k++) begin
			case ($urandom_range(0, 5))
			0: t = smpc_pkg::AttrUsername;
			1: t = smpc_pkg::AttrIntegrity;
			2: t = smpc_pkg::AttrPriority;
			3: t = smpc_pkg::AttrFingerprint;
			default: t = 16'($urandom);
			endcase
			len = (t == smpc_pkg::AttrPriority) ? 4 :
				(t == smpc_pkg::AttrIntegrity ? 20 : $urandom_range(0, 40));
			put_attr(t, len, (len + 3) & ~3);
		end
		// header length counts the fingerprint, its crc stops before it
		body = dg.size() - 20 + (with_fp ? 8 : 0);
		dg[2] = body[15:8]; dg[3] = body[7:0];
		if (with_fp) begin
			c = '1;
			foreach (dg[i]) c = crc_step(c, dg[i]);
			put_attr(smpc_pkg::AttrFingerprint, 4, 0);
			put32(~c ^ smpc_pkg::FpXor ^
				(corrupt_fp ? 32'(1 << $urandom_range(0, 31)) : 32'd0));
		end
	endtask

	task automatic queue_message();
		req_t r;
		foreach (dg[i]) begin
			r.data = dg[i];
			r.last = (i == dg.size() - 1);
			pending_bytes = {pending_bytes, r};
		end
		queued += dg.size();
	endtask

	task automatic queue_noise(int len);
		dg.delete();
		for (int i = 0; i < len; i++) put8(8'($urandom));
		queue_message();
	endtask

	task automatic wait_drained();
		while (pending_bytes.size() != 0 || in_valid || expected_verdicts.size() != 0)
			@(posedge clk);
	endtask

	// driver
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (pending_bytes.size() != 0 && !sender_pause &&
					(calm || $urandom_range(0, 99) >= 6)) begin
				req_t r;
				r = pending_bytes.pop_front();
				in_valid <= 1'b1;
				data_byte <= r.data;
				end_of_datagram <= r.last;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver ready with its own hold-off count
	always @(negedge clk) begin
		if (rx_hold > 0) begin
			out_ready <= 1'b0;
			rx_hold <= rx_hold - 1;
		end else begin
			out_ready <= arst_n && (calm || $urandom_range(0, 99) >= 6);
		end
	end

	// input monitor: prediction on each accepted request
	always @(posedge clk) begin
		in_taken = arst_n && in_valid && in_ready;
		if (in_taken)
			predict_byte('{data_byte, end_of_datagram});
	end

	// output monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			verdict_t got, exp;
			got = '{status, message_type, cookie_ok, txn_id_high, txn_id_low, fingerprint_ok,
				has_integrity, integrity_offset, has_priority, priority_value,
				has_username, username_length};
			if (expected_verdicts.size() == 0) begin
				$display("%0t: unexpected result status=%0d", $time, status);
				failures++;
			end else begin
				exp = expected_verdicts.pop_front();
				if (got != exp) begin
					$display("%0t: mismatch exp=%h got=%h", $time, exp, got);
					if (got.status != exp.status)
						$display("%0t:   status exp=%0d got=%0d", $time, exp.status, got.status);
					if (got.fp != exp.fp)
						$display("%0t:   fingerprint exp=%0d got=%0d", $time, exp.fp, got.fp);
					failures++;
				end
			end
		end
	end

	initial begin
		int len;
		parser_clear();
		repeat (11) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// directed: short datagrams, not-stun bit, bad lengths, overruns, fingerprints
		for (int l = 1; l <= 3; l++) queue_noise(l);
		dg.delete(); dg = '{8'h08, 8'h01}; queue_message();
		dg.delete(); dg = '{8'hff, 8'hff, 8'h00}; queue_message();
		queue_noise(19);
		build_message(1, 0); queue_message();
		build_message(1, 1); queue_message();
		build_message(0, 0); queue_message();
		build_message(1, 0); dg[7] ^= 8'h01; queue_message();   // legacy cookie
		build_message(1, 0); dg[3] ^= 8'h04; queue_message();   // length mismatch
		build_message(0, 0); put_attr(smpc_pkg::AttrUsername, 5, 3); // ends inside value
		dg[2] = 8'((dg.size() - 20) >> 8); dg[3] = 8'(dg.size() - 20); queue_message();
		build_message(0, 0); put_attr(smpc_pkg::AttrPriority, 5, 8); // bad priority length
		dg[2] = 8'((dg.size() - 20) >> 8); dg[3] = 8'(dg.size() - 20); queue_message();
		build_message(0, 0); put_attr(smpc_pkg::AttrUsername, 16'hffff, 4); // wide length
		queue_message();
		wait_drained();

		// receiver holds off long while the sender keeps offering
		rx_hold = 300;
		for (int k = 0; k < 8; k++) queue_noise($urandom_range(1, 6));
		wait_drained();

		// random: mostly well-formed messages, the rest noise and broken ones
		while (queued < 1160) begin
			if ($urandom_range(0, 9) < 7) begin
				build_message($urandom_range(0, 3) != 0, $urandom_range(0, 7) == 0);
				if ($urandom_range(0, 9) == 0) begin
					len = $urandom_range(1, dg.size() - 1);
					while (dg.size() > len) void'(dg.pop_back());
				end
				if ($urandom_range(0, 19) == 0) dg[$urandom_range(0, dg.size() - 1)] ^= 8'($urandom);
				queue_message();
			end else begin
				queue_noise($urandom_range(1, 30));
			end
		end
		calm = 1;
		wait_drained();
		calm = 0;
		sender_pause = 1;
		repeat (20) @(posedge clk);
		sender_pause = 0;
		for (int k = 0; k < 2; k++) begin
			build_message(1, 0); queue_message();
		end
		wait_drained();
		repeat (20) @(posedge clk);
		if (failures == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#20ms;
		$display("TB_ERROR");
		$finish;
	end

endmodule

>>> filelist.f
rtl/smpc_pkg.sv
rtl/smpc_front.sv
rtl/smpc_queue.sv
rtl/smpc_back.sv
rtl/stun_message_parse_check.sv
tb/tb_top.sv
